// ===== sv/wapsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the position to step rate unit.
package wapsr_pkg;

  typedef logic [1:0]         command_t;
  typedef logic [18:0]        raw_t;
  typedef logic signed [18:0] angle_t;
  typedef logic signed [19:0] target_t;
  typedef logic [15:0]        speed_t;
  typedef logic [17:0]        rate_t;
  typedef logic [15:0]        tol_t;
  typedef logic [7:0]         gear_t;
  typedef logic [15:0]        micro_t;
  typedef logic [2:0]         reg_idx_t;
  typedef logic [2:0]         op_t;

  localparam command_t CMD_UPDATE = 2'd0;
  localparam command_t CMD_TARGET = 2'd1;
  localparam command_t CMD_ZERO   = 2'd2;
  localparam command_t CMD_STOP   = 2'd3;

  localparam reg_idx_t REG_TOL        = 3'd0;
  localparam reg_idx_t REG_LIMIT_LOW  = 3'd1;
  localparam reg_idx_t REG_LIMIT_HIGH = 3'd2;
  localparam reg_idx_t REG_DFLT_SPEED = 3'd3;
  localparam reg_idx_t REG_MIN_RATE   = 3'd4;
  localparam reg_idx_t REG_MAX_RATE   = 3'd5;
  localparam reg_idx_t REG_GEAR       = 3'd6;
  localparam reg_idx_t REG_MICRO      = 3'd7;

  localparam tol_t   RST_TOL        = 16'd100;
  localparam angle_t RST_LIMIT_LOW  = -19'sd180000;
  localparam angle_t RST_LIMIT_HIGH = 19'sd180000;
  localparam speed_t RST_DFLT_SPEED = 16'd30000;
  localparam rate_t  RST_MIN_RATE   = 18'd50;
  localparam rate_t  RST_MAX_RATE   = 18'd20000;
  localparam gear_t  RST_GEAR       = 8'd21;
  localparam micro_t RST_MICRO      = 16'd3200;

  localparam logic signed [20:0] HALF_TURN = 21'sd180000;
  localparam logic signed [20:0] FULL_TURN = 21'sd360000;
  localparam logic [17:0]        FULL_SPEED_ERR = 18'd30000;

  // 360000 = 64 * 5625 and 30000 = 16 * 1875: shift, then divide by the odd part
  localparam logic [12:0] DIV_A   = 13'd5625;
  localparam logic [12:0] DIV_B   = 13'd1875;
  localparam logic [19:0] RECIP_A = 20'((64'd1 << 32) / 64'd5625);
  localparam logic [19:0] RECIP_B = 20'((64'd1 << 30) / 64'd1875);
  // quotient at or above 2^18 exceeds every maximum rate
  localparam logic [33:0] SAT_Y   = 34'd5625 << 18;

  localparam op_t OP_NONE  = 3'd0;
  localparam op_t OP_EXEC  = 3'd1;
  localparam op_t OP_ERR   = 3'd2;
  localparam op_t OP_DIVA  = 3'd3;
  localparam op_t OP_DIVB  = 3'd4;
  localparam op_t OP_DIVC  = 3'd5;
  localparam op_t OP_HZMUL = 3'd6;

  typedef struct packed {
    tol_t   tol;
    angle_t limit_low;
    angle_t limit_high;
    speed_t dflt_speed;
    rate_t  min_rate;
    rate_t  max_rate;
    gear_t  gear;
    micro_t micro;
  } cfg_t;

  typedef struct packed {
    logic take;
    op_t  op;
    logic div_sel;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    command_t command;
    logic     ok;
    logic     moving;
    logic     in_tol;
    logic     err_big;
  } dp_stat_t;

endpackage

// ===== sv/wapsr_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: one command with encoder sample and target.
interface wapsr_req_if import wapsr_pkg::*; ();
  logic     valid;
  logic     ready;
  command_t command;
  raw_t     raw_angle;
  logic     sensor_ok;
  target_t  target_angle;
  speed_t   speed_limit;

  modport source (output valid, command, raw_angle, sensor_ok, target_angle, speed_limit,
                  input ready);
  modport sink (input valid, command, raw_angle, sensor_ok, target_angle, speed_limit,
                output ready);
endinterface

// ===== sv/wapsr_res_if.sv =====
`timescale 1ns / 1ps
// Result channel: drive command and controller status after each request.
interface wapsr_res_if import wapsr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   target_accepted;
  logic   drive_running;
  logic   drive_forward;
  rate_t  step_rate;
  angle_t current_angle;
  logic   moving;
  logic   on_target;
  logic   encoder_good;
  logic   zero_set;

  modport source (output valid, target_accepted, drive_running, drive_forward, step_rate,
                  current_angle, moving, on_target, encoder_good, zero_set,
                  input ready);
  modport sink (input valid, target_accepted, drive_running, drive_forward, step_rate,
                current_angle, moving, on_target, encoder_good, zero_set,
                output ready);
endinterface

// ===== sv/wapsr_regs.sv =====
`timescale 1ns / 1ps
// APB configuration register bank.
module wapsr_regs import wapsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tol        <= RST_TOL;
      cfg.limit_low  <= RST_LIMIT_LOW;
      cfg.limit_high <= RST_LIMIT_HIGH;
      cfg.dflt_speed <= RST_DFLT_SPEED;
      cfg.min_rate   <= RST_MIN_RATE;
      cfg.max_rate   <= RST_MAX_RATE;
      cfg.gear       <= RST_GEAR;
      cfg.micro      <= RST_MICRO;
    end else if (wr) begin
      unique case (idx)
        REG_TOL:        cfg.tol        <= pwdata[15:0];
        REG_LIMIT_LOW:  cfg.limit_low  <= pwdata[18:0];
        REG_LIMIT_HIGH: cfg.limit_high <= pwdata[18:0];
        REG_DFLT_SPEED: cfg.dflt_speed <= pwdata[15:0];
        REG_MIN_RATE:   cfg.min_rate   <= pwdata[17:0];
        REG_MAX_RATE:   cfg.max_rate   <= pwdata[17:0];
        REG_GEAR:       cfg.gear       <= pwdata[7:0];
        REG_MICRO:      cfg.micro      <= pwdata[15:0];
        default:        cfg.tol        <= cfg.tol;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TOL:        prdata = {16'd0, cfg.tol};
      REG_LIMIT_LOW:  prdata = {{13{cfg.limit_low[18]}}, cfg.limit_low};
      REG_LIMIT_HIGH: prdata = {{13{cfg.limit_high[18]}}, cfg.limit_high};
      REG_DFLT_SPEED: prdata = {16'd0, cfg.dflt_speed};
      REG_MIN_RATE:   prdata = {14'd0, cfg.min_rate};
      REG_MAX_RATE:   prdata = {14'd0, cfg.max_rate};
      REG_GEAR:       prdata = {24'd0, cfg.gear};
      REG_MICRO:      prdata = {16'd0, cfg.micro};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/wapsr_dp.sv =====
`timescale 1ns / 1ps
// Datapath: controller state, angle wrap, error, rate multiply and constant division.
module wapsr_dp import wapsr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  command_t in_command,
  input  raw_t     in_raw_angle,
  input  logic     in_sensor_ok,
  input  target_t  in_target_angle,
  input  speed_t   in_speed_limit,
  output logic     out_target_accepted,
  output logic     out_drive_running,
  output logic     out_drive_forward,
  output rate_t    out_step_rate,
  output angle_t   out_current_angle,
  output logic     out_moving,
  output logic     out_on_target,
  output logic     out_encoder_good,
  output logic     out_zero_set
);

  command_t it_command;
  raw_t     it_raw;
  logic     it_ok;
  target_t  it_target;
  speed_t   it_speed;

  angle_t target_reg;
  angle_t current_reg;
  raw_t   zero_offset;
  speed_t speed_reg;
  rate_t  rate_reg;
  logic   moving_flag;
  logic   reached_flag;
  logic   sensor_flag;
  logic   zeroed_flag;
  logic   run_flag;
  logic   dir_flag;
  logic   accepted;

  logic [23:0] prod1;
  logic [39:0] prod2;
  logic [32:0] hzprod;
  logic [17:0] ae_reg;
  rate_t       maxhz_reg;
  logic [30:0] dv_y;
  logic [17:0] dv_q;
  logic [13:0] dv_r;
  logic        dv_sat;

  logic signed [20:0] zdiff, zwrap, ediff, ewrap;
  logic [20:0] eabs;
  logic [17:0] ae;
  logic        in_tol;
  speed_t      spd_eff;
  logic        tgt_ok;
  logic [33:0] y_a;
  logic        sat_a;
  logic [30:0] y_src;
  logic [19:0] recip;
  logic [12:0] dvsr;
  logic [50:0] mprod;
  logic [17:0] q0;
  logic [31:0] qd;
  logic [31:0] rem_full;
  logic [17:0] qf;
  rate_t       mh;
  rate_t       hz;

  always_comb begin
    zdiff = $signed({2'b00, it_raw}) - $signed({2'b00, zero_offset});
    if (zdiff > HALF_TURN) begin
      zwrap = zdiff - FULL_TURN;
    end else if (zdiff <= -HALF_TURN) begin
      zwrap = zdiff + FULL_TURN;
    end else begin
      zwrap = zdiff;
    end

    ediff = $signed({{2{target_reg[18]}}, target_reg})
          - $signed({{2{current_reg[18]}}, current_reg});
    if (ediff > HALF_TURN) begin
      ewrap = ediff - FULL_TURN;
    end else if (ediff <= -HALF_TURN) begin
      ewrap = ediff + FULL_TURN;
    end else begin
      ewrap = ediff;
    end
    eabs   = ewrap[20] ? 21'(-ewrap) : 21'(ewrap);
    ae     = eabs[17:0];
    in_tol = ae <= {2'b00, cfg.tol};

    spd_eff = (speed_reg != 16'd0) ? speed_reg : cfg.dflt_speed;
    tgt_ok  = (it_target >= $signed({cfg.limit_low[18], cfg.limit_low}))
           && (it_target <= $signed({cfg.limit_high[18], cfg.limit_high}));

    y_a   = prod2[39:6];
    sat_a = y_a >= SAT_Y;
    y_src = cmd.div_sel ? 31'(hzprod[32:4]) : y_a[30:0];
    recip = cmd.div_sel ? RECIP_B : RECIP_A;
    dvsr  = cmd.div_sel ? DIV_B : DIV_A;
    mprod = 51'(y_src) * 51'(recip);
    q0    = cmd.div_sel ? mprod[47:30] : mprod[49:32];

    qd       = 32'(dv_q) * 32'(dvsr);
    rem_full = 32'(dv_y) - qd;
    qf       = dv_q + 18'(dv_r >= {1'b0, dvsr});

    mh = (dv_sat || (qf > cfg.max_rate)) ? cfg.max_rate : qf;
    if (mh < cfg.min_rate) begin
      mh = cfg.min_rate;
    end
    hz = qf;
    if (hz < cfg.min_rate) begin
      hz = cfg.min_rate;
    end
    if (hz > maxhz_reg) begin
      hz = maxhz_reg;
    end
  end

  assign stat.command = it_command;
  assign stat.ok      = it_ok;
  assign stat.moving  = moving_flag;
  assign stat.in_tol  = in_tol;
  assign stat.err_big = ae_reg >= FULL_SPEED_ERR;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_command <= in_command;
      it_raw     <= in_raw_angle;
      it_ok      <= in_sensor_ok;
      it_target  <= in_target_angle;
      it_speed   <= in_speed_limit;
    end
    unique case (cmd.op)
      OP_EXEC:  prod1 <= 24'(spd_eff) * 24'(cfg.gear);
      OP_ERR: begin
        prod2  <= 40'(prod1) * 40'(cfg.micro);
        ae_reg <= ae;
      end
      OP_DIVA: begin
        dv_y   <= y_src;
        dv_q   <= q0;
        dv_sat <= !cmd.div_sel && sat_a;
      end
      OP_DIVB:  dv_r <= rem_full[13:0];
      OP_DIVC: begin
        if (!cmd.div_sel) begin
          maxhz_reg <= mh;
        end
      end
      OP_HZMUL: hzprod <= 33'(maxhz_reg) * 33'(ae_reg[14:0]);
      OP_NONE:  dv_r <= dv_r;
      default:  dv_r <= dv_r;
    endcase
    if (cmd.load_out) begin
      out_target_accepted <= accepted;
      out_drive_running   <= run_flag;
      out_drive_forward   <= dir_flag;
      out_step_rate       <= rate_reg;
      out_current_angle   <= current_reg;
      out_moving          <= moving_flag;
      out_on_target       <= reached_flag;
      out_encoder_good    <= sensor_flag;
      out_zero_set        <= zeroed_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_reg   <= '0;
      current_reg  <= '0;
      zero_offset  <= '0;
      speed_reg    <= '0;
      rate_reg     <= '0;
      moving_flag  <= 1'b0;
      reached_flag <= 1'b0;
      sensor_flag  <= 1'b0;
      zeroed_flag  <= 1'b0;
      run_flag     <= 1'b0;
      dir_flag     <= 1'b0;
      accepted     <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_EXEC: begin
          accepted <= 1'b0;
          unique case (it_command)
            CMD_UPDATE: begin
              sensor_flag <= it_ok;
              if (!it_ok) begin
                run_flag    <= 1'b0;
                rate_reg    <= '0;
                moving_flag <= 1'b0;
              end else begin
                current_reg <= zwrap[18:0];
              end
            end
            CMD_TARGET: begin
              if (tgt_ok) begin
                target_reg   <= it_target[18:0];
                speed_reg    <= it_speed;
                moving_flag  <= 1'b1;
                reached_flag <= 1'b0;
                accepted     <= 1'b1;
              end
            end
            CMD_ZERO: begin
              if (it_ok) begin
                zero_offset  <= it_raw;
                zeroed_flag  <= 1'b1;
                target_reg   <= '0;
                reached_flag <= 1'b0;
                moving_flag  <= 1'b0;
                run_flag     <= 1'b0;
                rate_reg     <= '0;
              end
            end
            CMD_STOP: begin
              moving_flag  <= 1'b0;
              reached_flag <= 1'b0;
              run_flag     <= 1'b0;
              rate_reg     <= '0;
            end
            default: accepted <= 1'b0;
          endcase
        end
        OP_ERR: begin
          if (in_tol) begin
            run_flag     <= 1'b0;
            rate_reg     <= '0;
            moving_flag  <= 1'b0;
            reached_flag <= 1'b1;
          end else begin
            dir_flag <= ewrap > 21'sd0;
          end
        end
        OP_DIVC: begin
          if (cmd.div_sel) begin
            rate_reg <= hz;
            run_flag <= 1'b1;
          end else if (stat.err_big) begin
            rate_reg <= mh;
            run_flag <= 1'b1;
          end
        end
        OP_NONE, OP_DIVA, OP_DIVB, OP_HZMUL: run_flag <= run_flag;
        default: run_flag <= run_flag;
      endcase
    end
  end

endmodule

// ===== sv/wapsr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: request handshake, step sequencing and result register.
module wapsr_ctrl import wapsr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     res_valid,
  input  logic     res_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_ERR   = 3'd2;
  localparam logic [2:0] ST_DIVA  = 3'd3;
  localparam logic [2:0] ST_DIVB  = 3'd4;
  localparam logic [2:0] ST_DIVC  = 3'd5;
  localparam logic [2:0] ST_HZMUL = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state, state_next;
  logic       pass, pass_next;
  logic       res_valid_next;

  assign req_ready = state == ST_IDLE;

  always_comb begin
    state_next   = state;
    pass_next    = pass;
    cmd.take     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.div_sel  = pass;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.op = OP_EXEC;
        if (stat.command == CMD_UPDATE && stat.ok && stat.moving) begin
          state_next = ST_ERR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_ERR: begin
        cmd.op     = OP_ERR;
        pass_next  = 1'b0;
        state_next = stat.in_tol ? ST_DONE : ST_DIVA;
      end
      ST_DIVA: begin
        cmd.op     = OP_DIVA;
        state_next = ST_DIVB;
      end
      ST_DIVB: begin
        cmd.op     = OP_DIVB;
        state_next = ST_DIVC;
      end
      ST_DIVC: begin
        cmd.op     = OP_DIVC;
        state_next = (!pass && !stat.err_big) ? ST_HZMUL : ST_DONE;
      end
      ST_HZMUL: begin
        cmd.op     = OP_HZMUL;
        pass_next  = 1'b1;
        state_next = ST_DIVA;
      end
      ST_DONE: begin
        if (!res_valid || res_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    res_valid_next = cmd.load_out ? 1'b1 : (res_ready ? 1'b0 : res_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pass      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pass      <= pass_next;
      res_valid <= res_valid_next;
    end
  end

  a_take: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_EXEC))
    else $error("accepted request did not start execution");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!res_valid || res_ready)) |=> (res_valid && state == ST_IDLE))
    else $error("finished request not presented as a result");

  a_hz: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HZMUL) |=> (state == ST_DIVA && pass))
    else $error("rate scaling did not enter second division pass");

  a_pass: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVC && pass) |=> (state == ST_DONE))
    else $error("second division pass did not finish the request");

endmodule

// ===== sv/wrap_aware_position_to_step_rate_unit.sv =====
`timescale 1ns / 1ps
// Top level of the wrap aware position to step rate unit.
// Each request carries one command (update, set target, set zero, stop) and yields exactly
// one result holding the drive command and controller status after that command. Requests
// are handled one at a time, with a result register so a new request is taken while the
// previous result waits. Set target, set zero, stop and updates needing no new rate pass
// the execute and done steps; an update inside tolerance also passes the error step, one
// far from the target (30 degrees or more) adds one divider pass, one close to it the rate
// scaling and a second pass. The sequencer walks a single 16x8 and 24x16 multiply chain
// and a shared reciprocal divider (multiply, remainder, correct) used once for the maximum
// rate and, near the target, again for the proportional rate. Configuration must be written
// over the APB port only while no request is in progress; the unit does not enforce this.
module wrap_aware_position_to_step_rate_unit import wapsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  wapsr_req_if.sink   req,
  wapsr_res_if.source res
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  wapsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wapsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wapsr_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .stat                (stat),
    .in_command          (req.command),
    .in_raw_angle        (req.raw_angle),
    .in_sensor_ok        (req.sensor_ok),
    .in_target_angle     (req.target_angle),
    .in_speed_limit      (req.speed_limit),
    .out_target_accepted (res.target_accepted),
    .out_drive_running   (res.drive_running),
    .out_drive_forward   (res.drive_forward),
    .out_step_rate       (res.step_rate),
    .out_current_angle   (res.current_angle),
    .out_moving          (res.moving),
    .out_on_target       (res.on_target),
    .out_encoder_good    (res.encoder_good),
    .out_zero_set        (res.zero_set)
  );

endmodule

// ===== test/wapsr_checker.sv =====
`timescale 1ns / 1ps
// Status checker: mirrors the register writes, predicts each result and compares it.
module wapsr_checker import wapsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  wapsr_req_if        req,
  wapsr_res_if        res,
  output int          fails,
  output int          outstanding
);

  typedef struct packed {
    logic   accepted;
    logic   running;
    logic   forward;
    rate_t  rate;
    angle_t angle;
    logic   moving;
    logic   reached;
    logic   enc_ok;
    logic   zeroed;
  } status_t;

  cfg_t    cfg;
  angle_t  goal;
  angle_t  position;
  raw_t    offset;
  speed_t  spd_req;
  rate_t   rate;
  logic    is_moving, is_reached, enc_ok, is_zeroed, running, forward;
  status_t status_q[$];

  function automatic int wrap_turn(int d);
    while (d > HALF_TURN) d -= FULL_TURN;
    while (d <= -HALF_TURN) d += FULL_TURN;
    return d;
  endfunction

  function automatic void halt_drive();
    running = 1'b0;
    rate = '0;
  endfunction

  function automatic rate_t rate_for_error(int unsigned err_mag);
    longint unsigned top_hz, hz;
    top_hz = (spd_req != 0) ? spd_req : cfg.dflt_speed;
    top_hz = top_hz * cfg.gear * cfg.micro / 64'd360000;
    if (top_hz > cfg.max_rate) top_hz = cfg.max_rate;
    if (top_hz < cfg.min_rate) top_hz = cfg.min_rate;
    if (err_mag >= FULL_SPEED_ERR) hz = top_hz;
    else hz = top_hz * err_mag / FULL_SPEED_ERR;
    if (hz < cfg.min_rate) hz = cfg.min_rate;
    if (hz > top_hz) hz = top_hz;
    return rate_t'(hz);
  endfunction

  function automatic status_t advance_controller(command_t cmd, raw_t raw, logic ok,
                                                 target_t tgt, speed_t spd);
    status_t s;
    int err;
    int unsigned mag;
    s.accepted = 1'b0;
    case (cmd)
      CMD_UPDATE: begin
        enc_ok = ok;
        if (!ok) begin
          halt_drive();
          is_moving = 1'b0;
        end else begin
          position = angle_t'(wrap_turn(int'(raw) - int'(offset)));
          if (is_moving) begin
            err = wrap_turn(int'(goal) - int'(position));
            mag = (err < 0) ? -err : err;
            if (mag <= cfg.tol) begin
              halt_drive();
              is_moving = 1'b0;
              is_reached = 1'b1;
            end else begin
              forward = (err > 0);
              rate = rate_for_error(mag);
              running = 1'b1;
            end
          end
        end
      end
      CMD_TARGET: begin
        if (int'(tgt) >= int'(cfg.limit_low) && int'(tgt) <= int'(cfg.limit_high)) begin
          goal = tgt[18:0];
          spd_req = spd;
          is_moving = 1'b1;
          is_reached = 1'b0;
          s.accepted = 1'b1;
        end
      end
      CMD_ZERO: begin
        if (ok) begin
          offset = raw;
          is_zeroed = 1'b1;
          goal = '0;
          is_reached = 1'b0;
          is_moving = 1'b0;
          halt_drive();
        end
      end
      CMD_STOP: begin
        is_moving = 1'b0;
        is_reached = 1'b0;
        halt_drive();
      end
    endcase
    s.running = running;
    s.forward = forward;
    s.rate    = rate;
    s.angle   = position;
    s.moving  = is_moving;
    s.reached = is_reached;
    s.enc_ok  = enc_ok;
    s.zeroed  = is_zeroed;
    return s;
  endfunction

  task automatic report(string what, longint want_v, longint got_v);
    fails++;
    $display("%0t ns: %s mismatch, predicted %0d, seen %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      cfg = '{RST_TOL, RST_LIMIT_LOW, RST_LIMIT_HIGH, RST_DFLT_SPEED,
              RST_MIN_RATE, RST_MAX_RATE, RST_GEAR, RST_MICRO};
      goal = '0;
      position = '0;
      offset = '0;
      spd_req = '0;
      rate = '0;
      is_moving = 1'b0;
      is_reached = 1'b0;
      enc_ok = 1'b0;
      is_zeroed = 1'b0;
      running = 1'b0;
      forward = 1'b0;
      status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_TOL:        cfg.tol        = pwdata[15:0];
          REG_LIMIT_LOW:  cfg.limit_low  = pwdata[18:0];
          REG_LIMIT_HIGH: cfg.limit_high = pwdata[18:0];
          REG_DFLT_SPEED: cfg.dflt_speed = pwdata[15:0];
          REG_MIN_RATE:   cfg.min_rate   = pwdata[17:0];
          REG_MAX_RATE:   cfg.max_rate   = pwdata[17:0];
          REG_GEAR:       cfg.gear       = pwdata[7:0];
          REG_MICRO:      cfg.micro      = pwdata[15:0];
        endcase
      end
      if (res.valid && res.ready) begin
        if (status_q.size() == 0) begin
          report("result with no request pending", 0, 1);
        end else begin
          want = status_q.pop_front();
          if (res.target_accepted !== want.accepted)
            report("target_accepted", want.accepted, res.target_accepted);
          if (res.drive_running !== want.running)
            report("drive_running", want.running, res.drive_running);
          if (res.drive_forward !== want.forward)
            report("drive_forward", want.forward, res.drive_forward);
          if (res.step_rate !== want.rate)
            report("step_rate", want.rate, res.step_rate);
          if (res.current_angle !== want.angle)
            report("current_angle", want.angle, res.current_angle);
          if (res.moving !== want.moving)
            report("moving", want.moving, res.moving);
          if (res.on_target !== want.reached)
            report("on_target", want.reached, res.on_target);
          if (res.encoder_good !== want.enc_ok)
            report("encoder_good", want.enc_ok, res.encoder_good);
          if (res.zero_set !== want.zeroed)
            report("zero_set", want.zeroed, res.zero_set);
        end
      end
      if (req.valid && req.ready)
        status_q.push_back(advance_controller(req.command, req.raw_angle, req.sensor_ok,
                                              req.target_angle, req.speed_limit));
    end
    outstanding = status_q.size();
  end

endmodule

// ===== test/wrap_aware_position_to_step_rate_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives requests and register writes into the unit and gives the verdict.
module wrap_aware_position_to_step_rate_unit_tb;
  import wapsr_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PATTERN, SINK_HOLD} sink_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fails, outstanding, cycles, sent, burst_left;
  int          zoff, pos, tol, lim_lo, lim_hi;
  bit          squeeze;

  wapsr_req_if req_ch ();
  wapsr_res_if res_ch ();

  wrap_aware_position_to_step_rate_unit dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req(req_ch), .res(res_ch)
  );

  wapsr_checker status_check (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .req(req_ch), .res(res_ch), .fails, .outstanding
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int fold(int d);
    while (d > 180000) d -= 360000;
    while (d <= -180000) d += 360000;
    return d;
  endfunction

  function automatic raw_t encoder_at(int angle);
    int v;
    v = (angle + zoff) % 360000;
    if (v < 0) v += 360000;
    return raw_t'(v);
  endfunction

  task automatic send(command_t cmd, raw_t raw, logic ok, target_t tgt, speed_t spd);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid        <= 1'b1;
    req_ch.command      <= cmd;
    req_ch.raw_angle    <= raw;
    req_ch.sensor_ok    <= ok;
    req_ch.target_angle <= tgt;
    req_ch.speed_limit  <= spd;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_settings(int t, int lo, int hi, int dflt, int mn, int mx,
                               int gear, int micro);
    write_reg(REG_TOL, t);
    write_reg(REG_LIMIT_LOW, lo);
    write_reg(REG_LIMIT_HIGH, hi);
    write_reg(REG_DFLT_SPEED, dflt);
    write_reg(REG_MIN_RATE, mn);
    write_reg(REG_MAX_RATE, mx);
    write_reg(REG_GEAR, gear);
    write_reg(REG_MICRO, micro);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tol    = t;
    lim_lo = lo;
    lim_hi = hi;
  endtask

  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  // set a target, then close in on it over a few encoder samples
  task automatic move_episode();
    int goal, steps, pick, near, k;
    speed_t spd;
    pick = $urandom_range(0, 9);
    if (pick == 9)
      goal = $signed(target_t'($urandom));
    else if (lim_lo > lim_hi || pick == 8)
      goal = int'($urandom_range(0, 720000)) - 360000;
    else if (pick == 7)
      goal = ($urandom_range(0, 1) != 0) ? lim_lo : lim_hi;
    else
      goal = lim_lo + int'($urandom_range(0, lim_hi - lim_lo));
    case ($urandom_range(0, 3))
      0:       spd = '0;
      1:       spd = 16'hFFFF;
      default: spd = speed_t'($urandom_range(1, 65535));
    endcase
    send(CMD_TARGET, raw_t'($urandom), 1'($urandom), target_t'(goal), spd);
    steps = $urandom_range(2, 10);
    for (k = 1; k <= steps; k++) begin
      if (k == steps) begin
        near = $urandom_range(0, tol + 1);
        pos = fold(goal + (($urandom_range(0, 1) != 0) ? near : -near));
      end else begin
        pos = fold(pos + fold(goal - pos) * int'($urandom_range(30, 95)) / 100
                   + int'($urandom_range(0, 400)) - 200);
      end
      send(CMD_UPDATE, encoder_at(pos), $urandom_range(0, 24) != 0,
           target_t'($urandom), speed_t'($urandom));
    end
  endtask

  task automatic run_random(int count);
    int stop_at, pick;
    raw_t raw;
    logic ok;
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        raw = ($urandom_range(0, 7) == 0) ? raw_t'($urandom_range(360000, 524287))
                                          : raw_t'($urandom_range(0, 359999));
        ok = ($urandom_range(0, 6) != 0);
        send(CMD_ZERO, raw, ok, target_t'($urandom), speed_t'($urandom));
        if (ok) zoff = raw;
      end else if (pick < 11) begin
        send(CMD_STOP, raw_t'($urandom), 1'($urandom), target_t'($urandom),
             speed_t'($urandom));
      end else if (pick < 19) begin
        send(command_t'($urandom), raw_t'($urandom), 1'($urandom), target_t'($urandom),
             speed_t'($urandom));
      end else begin
        move_episode();
      end
    end
  endtask

  initial begin : result_sink
    sink_mode_t mode;
    int pick, span, k;
    bit squeezed;
    squeezed = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      pick = $urandom_range(0, 31);
      span = $urandom_range(20, 120);
      mode = (pick < 12) ? SINK_OPEN : (pick < 22) ? SINK_RANDOM :
             (pick < 31) ? SINK_PATTERN : SINK_HOLD;
      if (mode == SINK_HOLD) span = $urandom_range(100, 250);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        mode = SINK_HOLD;
        span = 400;
      end
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          SINK_OPEN:    res_ch.ready <= 1'b1;
          SINK_RANDOM:  res_ch.ready <= ($urandom_range(0, 9) < 6);
          SINK_PATTERN: res_ch.ready <= ((k % 5) >= 2);
          SINK_HOLD:    res_ch.ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_UPDATE;
    req_ch.raw_angle = '0;
    req_ch.sensor_ok = 1'b0;
    req_ch.target_angle = '0;
    req_ch.speed_limit = '0;
    zoff = 0;
    pos = 0;
    tol = RST_TOL;
    lim_lo = RST_LIMIT_LOW;
    lim_hi = RST_LIMIT_HIGH;
    squeeze = 1'b0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(CMD_UPDATE, '0, 1'b1, '0, '0);
    send(CMD_UPDATE, 19'd359999, 1'b0, '0, '0);
    send(CMD_ZERO, 19'd12345, 1'b0, '0, '0);
    send(CMD_ZERO, 19'd359999, 1'b1, '0, '0);
    zoff = 359999;
    send(CMD_TARGET, '0, 1'b1, 20'sd360000, '0);
    send(CMD_TARGET, '0, 1'b1, 20'h80000, '0);
    send(CMD_TARGET, '0, 1'b1, 20'h7FFFF, '0);
    send(CMD_TARGET, '0, 1'b0, 20'sd90000, '0);
    send(CMD_UPDATE, encoder_at(0), 1'b1, '0, '0);
    send(CMD_UPDATE, encoder_at(75000), 1'b1, '0, '0);
    send(CMD_UPDATE, encoder_at(89900), 1'b1, '0, '0);
    send(CMD_TARGET, '0, 1'b1, -20'sd180000, 16'hFFFF);
    send(CMD_UPDATE, encoder_at(170000), 1'b1, '0, '0);
    send(CMD_UPDATE, 19'h7FFFF, 1'b1, '0, '0);
    send(CMD_UPDATE, encoder_at(-179899), 1'b1, '0, '0);
    send(CMD_STOP, 19'h7FFFF, 1'b1, 20'hFFFFF, 16'hFFFF);
    send(CMD_UPDATE, encoder_at(0), 1'b1, '0, '0);
    send(CMD_ZERO, '0, 1'b1, '0, '0);
    zoff = 0;
    send(CMD_TARGET, '0, 1'b1, 20'sd1000, 16'd1);
    send(CMD_UPDATE, '0, 1'b1, '0, '0);
    send(CMD_UPDATE, '0, 1'b0, '0, '0);
    send(CMD_UPDATE, '0, 1'b1, '0, '0);
    send(CMD_TARGET, '0, 1'b1, 20'sd180001, '0);

    squeeze = 1'b1;
    run_random(300);
    settle();
    load_settings(0, -180000, 180000, 65535, 0, 262143, 255, 65535);
    run_random(300);
    settle();
    // crossed soft limits, minimum rate above maximum
    load_settings(65535, 180000, -180000, 1, 262143, 1, 1, 1);
    run_random(150);
    settle();
    // zero gear, microsteps and default speed
    load_settings(20, -180000, 180000, 0, 40, 20000, 0, 0);
    run_random(100);
    settle();
    load_settings(500, -90000, 90000, 5000, 10, 5000, 50, 1600);
    run_random(350);
    settle();
    load_settings($urandom_range(0, 3000), -int'($urandom_range(0, 180000)),
                  $urandom_range(0, 180000), $urandom_range(1, 65535),
                  $urandom_range(0, 3000), $urandom_range(1, 262143),
                  $urandom_range(1, 255), $urandom_range(1, 65535));
    run_random(350);
    settle();
    load_settings(RST_TOL, RST_LIMIT_LOW, RST_LIMIT_HIGH, RST_DFLT_SPEED,
                  RST_MIN_RATE, RST_MAX_RATE, RST_GEAR, RST_MICRO);
    run_random(300);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
